[rtl/u2a_pkg.sv]
package u2a_pkg;

	// Register map: word index of each configuration register
	localparam logic REG_OUTPUT_LIMIT = 1'b0;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [7:0] OUTPUT_LIMIT_RESET = 8'd31;

	// Continuation bytes still expected
	localparam logic [1:0] REM_NONE = 2'd0;
	localparam logic [1:0] REM_ONE  = 2'd1;
	localparam logic [1:0] REM_TWO  = 2'd2;

	localparam logic [15:0] CP_PRINT_MIN  = 16'h0020;
	localparam logic [15:0] CP_ASCII_END  = 16'h0080;
	localparam logic [15:0] CP_LATIN1_MIN = 16'h00C0;
	localparam logic [15:0] CP_LATIN1_MAX = 16'h00FF;
	localparam logic [15:0] CP_EXTA_MIN   = 16'h0100;
	localparam logic [15:0] CP_EXTA_MAX   = 16'h017F;

	// Fold tables, first character at the most significant byte
	localparam logic [64*8-1:0] LATIN1_FOLD = {
		"AAAAAAACEEEEIIIIDNOOOOOxOUUUUYTs",
		"aaaaaaaceeeeiiiidnooooo/ouuuuyty"
	};

	localparam logic [128*8-1:0] EXTA_FOLD = {
		"AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGg",
		"GgGgHhHhIiIiIiIiIiIiJjKkkLlLlLlL",
		"lLlNnNnNnnNnOoOoOoOoRrRrRrSsSsSs",
		"SsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs"
	};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic       char_valid;
		logic [6:0] char_out;
		logic       end_of_string;
	} out_item_t;

	function automatic logic [6:0] fold_latin1(input logic [5:0] idx);
		logic [7:0] ch;
		ch = LATIN1_FOLD[(7'd63 - {1'b0, idx}) * 8 +: 8];
		return ch[6:0];
	endfunction

	function automatic logic [6:0] fold_exta(input logic [6:0] idx);
		logic [7:0] ch;
		ch = EXTA_FOLD[(8'd127 - {1'b0, idx}) * 8 +: 8];
		return ch[6:0];
	endfunction

endpackage

[rtl/utf8_to_ascii_folder_top.sv]
// Each result item is registered into the output slot, or the skid slot if
// the output stalls. Throughput: one byte per cycle while in_ready is high;
// the skid slot holds one result, and in_ready drops while it is full.
// Reset: arst_n clears decode state, emitted count and both output slots, and
// sets output_limit to 31. The last byte of a string also clears decode state.
module utf8_to_ascii_folder_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  u2a_pkg::in_item_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output u2a_pkg::out_item_t                    out_data,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [u2a_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [u2a_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [u2a_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	logic [7:0]          output_limit_q;
	logic [1:0]          rem_q;
	logic [15:0]         accum_q;
	logic [7:0]          count_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	u2a_pkg::out_item_t  out_q;
	u2a_pkg::out_item_t  skid_q;

	logic                in_take;
	logic                out_take;
	logic                reg_sel;
	logic [7:0]          b;
	logic                last;
	logic                is_ascii;
	logic                is_lead2;
	logic                is_lead3;
	logic                have;
	logic [15:0]         cp;
	logic [1:0]          rem_d;
	logic [15:0]         accum_d;
	logic [7:0]          count_d;
	logic                fold_ok;
	logic [6:0]          fold_ch;
	logic                emit;
	u2a_pkg::out_item_t  res;

	assign pready   = 1'b1;
	assign reg_sel  = paddr[2];
	assign in_ready = !skid_valid_q;
	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Read back the limit register
	always_comb begin
		prdata = '0;
		if (reg_sel == u2a_pkg::REG_OUTPUT_LIMIT) begin
			prdata = {{(u2a_pkg::APB_DATA_W - 8){1'b0}}, output_limit_q};
		end
	end

	// Write the limit register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_limit_q <= u2a_pkg::OUTPUT_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready
				&& reg_sel == u2a_pkg::REG_OUTPUT_LIMIT) begin
			output_limit_q <= pwdata[7:0];
		end
	end

	// Decode one byte against the sequence state
	always_comb begin
		b        = in_data.in_byte;
		last     = in_data.is_last;
		is_ascii = !b[7];
		is_lead2 = (b[7:5] == 3'b110);
		is_lead3 = (b[7:4] == 4'b1110);
		have     = 1'b0;
		cp       = {8'h00, b};
		rem_d    = u2a_pkg::REM_NONE;
		accum_d  = accum_q;
		case (rem_q)
			u2a_pkg::REM_ONE: begin
				cp   = accum_q | {10'd0, b[5:0]};
				have = 1'b1;
			end
			u2a_pkg::REM_TWO: begin
				if (last) begin
					have = is_ascii;
				end else begin
					accum_d = accum_q | {4'd0, b[5:0], 6'd0};
					rem_d   = u2a_pkg::REM_ONE;
				end
			end
			default: begin
				have = is_ascii;
				if (is_lead2 && !last) begin
					accum_d = {5'd0, b[4:0], 6'd0};
					rem_d   = u2a_pkg::REM_ONE;
				end else if (is_lead3 && !last) begin
					accum_d = {b[3:0], 12'd0};
					rem_d   = u2a_pkg::REM_TWO;
				end
			end
		endcase
	end

	// Fold the code point to printable ASCII
	always_comb begin
		fold_ok = 1'b0;
		fold_ch = cp[6:0];
		if (cp < u2a_pkg::CP_ASCII_END) begin
			fold_ok = (cp >= u2a_pkg::CP_PRINT_MIN);
		end else if (cp >= u2a_pkg::CP_LATIN1_MIN && cp <= u2a_pkg::CP_LATIN1_MAX) begin
			fold_ok = 1'b1;
			fold_ch = u2a_pkg::fold_latin1(cp[5:0]);
		end else if (cp >= u2a_pkg::CP_EXTA_MIN && cp <= u2a_pkg::CP_EXTA_MAX) begin
			fold_ok = 1'b1;
			fold_ch = u2a_pkg::fold_exta(cp[6:0]);
		end
		emit    = have && fold_ok && (count_q < output_limit_q);
		count_d = emit ? count_q + 8'd1 : count_q;
		res.char_valid    = emit;
		res.char_out      = emit ? fold_ch : 7'd0;
		res.end_of_string = last;
	end

	// Advance sequence state; clear at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= u2a_pkg::REM_NONE;
			accum_q <= '0;
			count_q <= '0;
		end else if (in_take) begin
			if (last) begin
				rem_q   <= u2a_pkg::REM_NONE;
				accum_q <= '0;
				count_q <= '0;
			end else begin
				rem_q   <= rem_d;
				accum_q <= accum_d;
				count_q <= count_d;
			end
		end
	end

	// Output slot and skid slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_take) begin
			out_valid_q  <= skid_valid_q || in_take;
			skid_valid_q <= 1'b0;
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Hold result items in the output or skid slot
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (in_take) begin
			skid_q <= res;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full while output slot empty");

	a_no_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.char_valid) |-> (out_data.char_out == 7'd0))
		else $error("char_out nonzero without char_valid");

	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.char_valid) |-> (out_data.char_out >= 7'h20))
		else $error("emitted character below 0x20");

	a_rem_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != 2'd3)
		else $error("continuation count out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && in_data.is_last) |=> (rem_q == u2a_pkg::REM_NONE && count_q == 8'd0))
		else $error("string end did not clear decode state");

endmodule
